@@ src/utf8d_pkg.sv @@
package utf8d_pkg;

	localparam int CpWidth    = 21;
	localparam int MaxResults = 4;

	localparam logic [7:0] AsciiLimit  = 8'h80;
	localparam logic [7:0] Lead2Lo     = 8'hC2;
	localparam logic [7:0] Lead3Lo     = 8'hE0;
	localparam logic [7:0] Lead4Lo     = 8'hF0;
	localparam logic [7:0] LeadLimit   = 8'hF5;
	localparam logic [7:0] LeadF4      = 8'hF4;
	localparam logic [7:0] ContLo      = 8'h80;
	localparam logic [7:0] ContLimit   = 8'hC0;
	localparam logic [7:0] ContLoE0    = 8'hA0;
	localparam logic [7:0] ContLoF0    = 8'h90;
	localparam logic [7:0] ContLimitF4 = 8'h90;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic               is_raw;
		logic               is_error;
	} result_t;

	// all results caused by one byte, in order
	typedef struct packed {
		logic                          valid;
		result_t [MaxResults-1:0]      entries;
		logic [$clog2(MaxResults):0]   count;
		logic                          end_of_string;
	} bundle_t;

	// continuation bytes a lead needs, zero if not a multibyte lead
	function automatic logic [1:0] lead_length(input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		if (b >= Lead2Lo && b < Lead3Lo)
			n = 2'd1;
		else if (b >= Lead3Lo && b < Lead4Lo)
			n = 2'd2;
		else if (b >= Lead4Lo && b < LeadLimit)
			n = 2'd3;
		return n;
	endfunction

endpackage

@@ src/utf8d_ifs.sv @@
interface utf8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utf8d_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        is_raw;
	logic        is_error;
	logic        string_done;
	logic        last_of_run;

	modport source (output valid, output code_point, output is_raw, output is_error,
		output string_done, output last_of_run, input ready);
	modport sink (input valid, input code_point, input is_raw, input is_error,
		input string_done, input last_of_run, output ready);
endinterface

interface utf8d_cfg_if;
	logic valid;
	logic ready;
	logic ignore_errors;

	modport source (output valid, output ignore_errors, input ready);
	modport sink (input valid, input ignore_errors, output ready);
endinterface

@@ src/utf8_validating_decoder.sv @@
// UTF-8 decoder with validation. Bytes enter on byte_stream, one per transfer, with
// end_of_string on the last byte of each string; code points leave on code_points, one
// result per transfer. A byte passes an input register and the decode logic into a result
// register; the block sustains one byte per cycle while each byte yields at most one result
// and code_points is ready. A lenient replay of a broken sequence yields up to four results
// from one byte; the result register sends them on one per cycle while code_points is
// ready, and the next byte waits there. Bytes that yield nothing leave no result.
// ignore_errors selects lenient (1) or strict (0) handling; the user must write it through
// cfg only while the block is idle, which the block does not enforce. cfg is always ready.
module utf8_validating_decoder (
	input logic          clk,
	input logic          arst_n,
	utf8d_in_if.sink     byte_stream,
	utf8d_out_if.source  code_points,
	utf8d_cfg_if.sink    cfg
);
	import utf8d_pkg::*;

	logic    ignore_errors_q;
	logic    take;
	bundle_t bundle;
	result_t result;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_errors_q <= 1'b0;
		end else if (cfg.valid) begin
			ignore_errors_q <= cfg.ignore_errors;
		end
	end

	utf8d_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.ignore_errors (ignore_errors_q),
		.in_valid      (byte_stream.valid),
		.in_ready      (byte_stream.ready),
		.in_byte       (byte_stream.in_byte),
		.in_end        (byte_stream.end_of_string),
		.take          (take),
		.bundle        (bundle)
	);

	utf8d_burst u_burst (
		.clk         (clk),
		.arst_n      (arst_n),
		.bundle      (bundle),
		.take        (take),
		.out_valid   (code_points.valid),
		.out_ready   (code_points.ready),
		.result      (result),
		.string_done (code_points.string_done),
		.last_of_run (code_points.last_of_run)
	);

	assign code_points.code_point = result.code_point;
	assign code_points.is_raw     = result.is_raw;
	assign code_points.is_error   = result.is_error;

endmodule

@@ src/utf8d_decode.sv @@
module utf8d_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ignore_errors,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_end,
	input  logic             take,
	output utf8d_pkg::bundle_t bundle
);
	import utf8d_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	logic [1:0] expected_q, expected_n;
	logic [1:0] seen_q, seen_n;
	logic [7:0] lead_q, lead_n;
	logic       skip_q, skip_n;
	logic [7:0] held_q [2];
	logic       held_we;

	logic       cont;
	logic       ok;
	logic [7:0] lo;
	logic [7:0] hi;
	logic [1:0] fresh_len;
	logic [1:0] base;
	logic [CpWidth-1:0] cp;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			end_s1  <= in_end;
		end
	end

	// first continuation byte has a narrowed range after some leads
	always_comb begin
		lo = ContLo;
		hi = ContLimit;
		if (seen_q == 2'd0) begin
			if (lead_q == Lead3Lo)
				lo = ContLoE0;
			else if (lead_q == Lead4Lo)
				lo = ContLoF0;
			else if (lead_q == LeadF4)
				hi = ContLimitF4;
		end
	end

	assign cont      = (expected_q != 2'd0) && (seen_q < expected_q);
	assign ok        = (byte_s1 >= lo) && (byte_s1 < hi);
	assign fresh_len = lead_length(byte_s1);
	assign base      = seen_q + 2'd1;

	always_comb begin
		unique case (expected_q)
			2'd1:    cp = {10'd0, lead_q[4:0], byte_s1[5:0]};
			2'd2:    cp = {5'd0, lead_q[3:0], held_q[0][5:0], byte_s1[5:0]};
			default: cp = {lead_q[2:0], held_q[0][5:0], held_q[1][5:0], byte_s1[5:0]};
		endcase
	end

	always_comb begin
		expected_n    = expected_q;
		seen_n        = seen_q;
		lead_n        = lead_q;
		skip_n        = skip_q;
		held_we       = 1'b0;
		bundle        = '0;
		bundle.valid  = valid_s1;
		bundle.end_of_string = end_s1;

		if (skip_q) begin
			expected_n = 2'd0;
			seen_n     = 2'd0;
		end else if (cont && ok && (seen_q + 2'd1 == expected_q)) begin
			bundle.entries[0] = '{code_point: cp, is_raw: 1'b0, is_error: 1'b0};
			bundle.count      = 3'd1;
			expected_n        = 2'd0;
			seen_n            = 2'd0;
		end else if (cont && ok && !end_s1) begin
			held_we = 1'b1;
			seen_n  = seen_q + 2'd1;
		end else if (cont && !ignore_errors) begin
			bundle.entries[0] = '{code_point: {13'd0, lead_q}, is_raw: 1'b0, is_error: 1'b1};
			bundle.count      = 3'd1;
			expected_n        = 2'd0;
			seen_n            = 2'd0;
			skip_n            = !end_s1;
		end else begin
			expected_n = 2'd0;
			seen_n     = 2'd0;
			// lenient replay of the broken sequence ahead of the current byte
			if (cont) begin
				bundle.entries[0] = '{code_point: {13'd0, lead_q}, is_raw: 1'b1, is_error: 1'b0};
				bundle.entries[1] = '{code_point: {13'd0, held_q[0]}, is_raw: 1'b1,
					is_error: 1'b0};
				bundle.entries[2] = '{code_point: {13'd0, held_q[1]}, is_raw: 1'b1,
					is_error: 1'b0};
				bundle.count      = {1'b0, base};
			end
			if (byte_s1 < AsciiLimit) begin
				bundle.entries[bundle.count[1:0]] = '{code_point: {13'd0, byte_s1},
					is_raw: 1'b0, is_error: 1'b0};
				bundle.count = bundle.count + 3'd1;
			end else if (fresh_len != 2'd0 && !end_s1) begin
				lead_n     = byte_s1;
				expected_n = fresh_len;
			end else if (ignore_errors) begin
				bundle.entries[bundle.count[1:0]] = '{code_point: {13'd0, byte_s1},
					is_raw: 1'b1, is_error: 1'b0};
				bundle.count = bundle.count + 3'd1;
			end else begin
				bundle.entries[bundle.count[1:0]] = '{code_point: {13'd0, byte_s1},
					is_raw: 1'b0, is_error: 1'b1};
				bundle.count = bundle.count + 3'd1;
				skip_n       = !end_s1;
			end
		end

		if (end_s1) begin
			expected_n = 2'd0;
			seen_n     = 2'd0;
			skip_n     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= 2'd0;
			seen_q     <= 2'd0;
			lead_q     <= 8'd0;
			skip_q     <= 1'b0;
		end else if (valid_s1 && take) begin
			expected_q <= expected_n;
			seen_q     <= seen_n;
			lead_q     <= lead_n;
			skip_q     <= skip_n;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && take && held_we) begin
			held_q[seen_q[0]] <= byte_s1;
		end
	end

endmodule

@@ src/utf8d_burst.sv @@
module utf8d_burst (
	input  logic               clk,
	input  logic               arst_n,
	input  utf8d_pkg::bundle_t bundle,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output utf8d_pkg::result_t result,
	output logic               string_done,
	output logic               last_of_run
);
	import utf8d_pkg::*;

	logic    valid_s2;
	bundle_t bundle_s2;
	logic [1:0] idx_q;
	logic    last;

	assign last      = ({1'b0, idx_q} + 3'd1) == bundle_s2.count;
	assign take      = !valid_s2 || (out_ready && last);
	assign out_valid = valid_s2;
	assign result    = bundle_s2.entries[idx_q];
	assign last_of_run = last;
	// an error always closes the string's output
	assign string_done = result.is_error || (last && bundle_s2.end_of_string);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (take) begin
			valid_s2 <= bundle.valid && (bundle.count != 3'd0);
			idx_q    <= 2'd0;
		end else if (out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bundle_s2 <= bundle;
		end
	end

endmodule
